// File: design/mrre_pkg.sv
// ============================================================================
// mrre_pkg: shared types and constants of the bitmap row run-length encoder
// Sizes of the row buffer and code counters, and the command and status
// records that join the encoder controller and its datapath.
// ============================================================================
package mrre_pkg;

    // Row buffer depth and count cap
    localparam int ROW_BYTES = 32;
    localparam int MAX_COUNT = 255;
    // Longest code stream emitted for one row
    localparam int OUT_LIMIT = 64;

    localparam int ADDR_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int POS_W  = $clog2(ROW_BYTES + 1);
    localparam int CNT_W  = $clog2(MAX_COUNT + 1);
    localparam int SUM_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int OCNT_W = $clog2(OUT_LIMIT);
    localparam int LEN_W  = 7;

    // Segment count update
    typedef enum logic [2:0] {
        CNT_HOLD = 3'd0,
        CNT_ONE  = 3'd1,
        CNT_TWO  = 3'd2,
        CNT_INC  = 3'd3,
        CNT_TAIL = 3'd4,
        CNT_ZERO = 3'd5
    } cnt_sel_t;

    // Source of the next code byte
    typedef enum logic [1:0] {
        OSEL_ZERO  = 2'd0,
        OSEL_COUNT = 2'd1,
        OSEL_VALUE = 2'd2,
        OSEL_DATA  = 2'd3
    } out_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     read_pos;    // read buffer at segment start
        logic     read_next;   // read next address, shift compare window
        logic     take_first;  // capture first byte of segment
        cnt_sel_t cnt_sel;
        logic     pos_adv;     // move segment start past current segment
        logic     out_load;    // load a code byte into the output register
        out_sel_t out_sel;
        logic     seg_last;    // byte is the last one of its segment
    } mrre_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic one_left;    // only the segment's first byte remains in the row
        logic at_last;     // read data is the last byte of the row
        logic eq_first;    // read data equals the segment's first byte
        logic triple;      // three equal bytes end at the read data
        logic cnt_at_cap;  // one more count reaches the cap
        logic lit_last;    // read data is the last literal byte
        logic row_done;    // current segment ends the row
        logic limit_hit;   // next code byte is the last one allowed
        logic out_ok;      // output register can take a byte
    } mrre_stat_t;

endpackage

// File: design/mrre_ctrl.sv
// ============================================================================
// mrre_ctrl: encoder sequencer
// Loads row bytes, then walks the row segment by segment: scan for a run or
// a literal, then emit its code bytes through the datapath output register.
// ============================================================================
module mrre_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                row_valid,
    input  logic                row_end,
    output logic                row_stall,
    input  mrre_pkg::mrre_stat_t stat,
    output mrre_pkg::mrre_cmd_t  cmd
);
    import mrre_pkg::*;

    typedef enum logic [10:0] {
        S_LOAD        = 11'b000_0000_0001,
        S_SCAN_ISSUE  = 11'b000_0000_0010,
        S_SCAN_FIRST  = 11'b000_0000_0100,
        S_SCAN_SECOND = 11'b000_0000_1000,
        S_SCAN_RUN    = 11'b000_0001_0000,
        S_SCAN_LIT    = 11'b000_0010_0000,
        S_RUN_ZERO    = 11'b000_0100_0000,
        S_RUN_COUNT   = 11'b000_1000_0000,
        S_RUN_VALUE   = 11'b001_0000_0000,
        S_LIT_COUNT   = 11'b010_0000_0000,
        S_LIT_DATA    = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   final_byte;

    // Last code byte of the row: end of last segment, or output limit
    assign final_byte = (((state_reg == S_RUN_VALUE) ||
                          ((state_reg == S_LIT_DATA) && stat.lit_last)) && stat.row_done) ||
                        stat.limit_hit;

    assign row_stall = (state_reg != S_LOAD);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.cnt_sel = CNT_HOLD;
        cmd.out_sel = OSEL_ZERO;
        unique case (state_reg)
            S_LOAD:
            begin
                if (row_valid && row_end)
                begin
                    state_next = S_SCAN_ISSUE;
                end
            end
            S_SCAN_ISSUE:
            begin
                cmd.read_pos = 1'b1;
                state_next   = S_SCAN_FIRST;
            end
            S_SCAN_FIRST:
            begin
                cmd.take_first = 1'b1;
                cmd.read_next  = 1'b1;
                if (stat.one_left)
                begin
                    cmd.cnt_sel = CNT_ONE;
                    state_next  = S_LIT_COUNT;
                end
                else
                begin
                    state_next = S_SCAN_SECOND;
                end
            end
            S_SCAN_SECOND:
            begin
                cmd.read_next = 1'b1;
                if (stat.eq_first)
                begin
                    cmd.cnt_sel = CNT_TWO;
                    if (stat.at_last || (MAX_COUNT == 2))
                        state_next = S_RUN_ZERO;
                    else
                        state_next = S_SCAN_RUN;
                end
                else if (stat.at_last)
                begin
                    cmd.cnt_sel = CNT_TAIL;
                    state_next  = S_LIT_COUNT;
                end
                else
                begin
                    // count each literal byte once no triple starts at it
                    cmd.cnt_sel = CNT_ZERO;
                    state_next  = S_SCAN_LIT;
                end
            end
            S_SCAN_RUN:
            begin
                cmd.read_next = 1'b1;
                if (stat.eq_first)
                begin
                    cmd.cnt_sel = CNT_INC;
                    if (stat.at_last || stat.cnt_at_cap)
                        state_next = S_RUN_ZERO;
                end
                else
                begin
                    state_next = S_RUN_ZERO;
                end
            end
            S_SCAN_LIT:
            begin
                cmd.read_next = 1'b1;
                if (stat.triple)
                begin
                    state_next = S_LIT_COUNT;
                end
                else if (stat.at_last)
                begin
                    cmd.cnt_sel = CNT_TAIL;
                    state_next  = S_LIT_COUNT;
                end
                else
                begin
                    cmd.cnt_sel = CNT_INC;
                    if (stat.cnt_at_cap)
                        state_next = S_LIT_COUNT;
                end
            end
            S_RUN_ZERO:
            begin
                cmd.out_sel = OSEL_ZERO;
                if (stat.out_ok)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = final_byte ? S_LOAD : S_RUN_COUNT;
                end
            end
            S_RUN_COUNT:
            begin
                cmd.out_sel = OSEL_COUNT;
                if (stat.out_ok)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = final_byte ? S_LOAD : S_RUN_VALUE;
                end
            end
            S_RUN_VALUE:
            begin
                cmd.out_sel  = OSEL_VALUE;
                cmd.seg_last = 1'b1;
                if (stat.out_ok)
                begin
                    cmd.out_load = 1'b1;
                    cmd.pos_adv  = 1'b1;
                    state_next   = final_byte ? S_LOAD : S_SCAN_ISSUE;
                end
            end
            S_LIT_COUNT:
            begin
                cmd.out_sel = OSEL_COUNT;
                if (stat.out_ok)
                begin
                    // prefetch the first literal byte with the count
                    cmd.out_load = 1'b1;
                    cmd.read_pos = 1'b1;
                    state_next   = final_byte ? S_LOAD : S_LIT_DATA;
                end
            end
            S_LIT_DATA:
            begin
                cmd.out_sel  = OSEL_DATA;
                cmd.seg_last = stat.lit_last;
                if (stat.out_ok)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.lit_last)
                    begin
                        cmd.pos_adv = 1'b1;
                        state_next  = final_byte ? S_LOAD : S_SCAN_ISSUE;
                    end
                    else
                    begin
                        cmd.read_next = 1'b1;
                        state_next    = final_byte ? S_LOAD : S_LIT_DATA;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

endmodule

// File: design/mrre_dpath.sv
// ============================================================================
// mrre_dpath: row buffer and code datapath
// Holds the row buffer memory, the segment start and count, the compare
// window used while scanning, and the output register of the code stream.
// ============================================================================
module mrre_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          row_accept,
    input  logic [7:0]                    row_byte,
    input  logic                          row_end,
    input  mrre_pkg::mrre_cmd_t           cmd,
    output mrre_pkg::mrre_stat_t          stat,
    input  logic                          code_stall,
    output logic                          code_valid,
    output logic [7:0]                    code_byte,
    output logic                          code_end,
    output logic [mrre_pkg::LEN_W-1:0]    coded_length
);
    import mrre_pkg::*;

    // Row buffer
    logic [7:0]       mem [0:ROW_BYTES-1];
    logic [7:0]       rd_data_reg;

    logic [POS_W-1:0] fill_reg;
    logic [POS_W-1:0] fill_inc;
    logic [POS_W-1:0] row_len_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] addr_reg;
    logic [POS_W-1:0] dat_idx_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [7:0]       first_reg;
    logic [7:0]       prev1_reg;
    logic [7:0]       prev2_reg;
    logic [OCNT_W-1:0] ocnt_reg;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_end_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic [7:0]       out_byte_next;
    logic             out_final;

    logic [SUM_W-1:0] seg_end;
    logic [SUM_W-1:0] tail;
    logic [SUM_W-1:0] dat_inc;

    // Fill count saturates at the buffer depth
    assign fill_inc = (fill_reg < POS_W'(ROW_BYTES)) ? fill_reg + 1'b1 : fill_reg;

    // Load row bytes, restart on row end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            row_len_reg <= '0;
        end
        else if (row_accept)
        begin
            if (row_end)
            begin
                fill_reg    <= '0;
                row_len_reg <= fill_inc;
            end
            else
            begin
                fill_reg <= fill_inc;
            end
        end
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (row_accept && (fill_reg < POS_W'(ROW_BYTES)))
            mem[fill_reg[ADDR_W-1:0]] <= row_byte;
        if (cmd.read_pos)
            rd_data_reg <= mem[pos_reg[ADDR_W-1:0]];
        else if (cmd.read_next)
            rd_data_reg <= mem[addr_reg[ADDR_W-1:0]];
    end

    // Read address, index of read data, compare window
    always_ff @(posedge clk)
    begin
        if (cmd.read_pos)
        begin
            addr_reg    <= pos_reg + 1'b1;
            dat_idx_reg <= pos_reg;
        end
        else if (cmd.read_next)
        begin
            addr_reg    <= addr_reg + 1'b1;
            dat_idx_reg <= addr_reg;
            prev2_reg   <= prev1_reg;
            prev1_reg   <= rd_data_reg;
        end
        if (cmd.take_first)
            first_reg <= rd_data_reg;
    end

    assign seg_end = SUM_W'(pos_reg) + SUM_W'(cnt_reg);
    assign tail    = SUM_W'(row_len_reg - pos_reg);
    assign dat_inc = SUM_W'(dat_idx_reg) + 1'b1;

    // Segment count
    always_comb
    begin
        case (cmd.cnt_sel)
            CNT_HOLD: cnt_next = cnt_reg;
            CNT_ONE:  cnt_next = CNT_W'(1);
            CNT_TWO:  cnt_next = CNT_W'(2);
            CNT_INC:  cnt_next = cnt_reg + 1'b1;
            CNT_TAIL: cnt_next = (tail > SUM_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT)
                                                           : tail[CNT_W-1:0];
            CNT_ZERO: cnt_next = '0;
            default:  cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
    end

    // Segment start: clear on row end, advance after each segment
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (row_accept && row_end)
            pos_reg <= '0;
        else if (cmd.pos_adv)
            pos_reg <= seg_end[POS_W-1:0];
    end

    // Status
    assign stat.one_left   = (SUM_W'(pos_reg) + 1'b1) == SUM_W'(row_len_reg);
    assign stat.at_last    = dat_inc == SUM_W'(row_len_reg);
    assign stat.eq_first   = rd_data_reg == first_reg;
    assign stat.triple     = (prev2_reg == prev1_reg) && (prev1_reg == rd_data_reg);
    assign stat.cnt_at_cap = cnt_reg == CNT_W'(MAX_COUNT - 1);
    assign stat.lit_last   = dat_inc == seg_end;
    assign stat.row_done   = seg_end == SUM_W'(row_len_reg);
    assign stat.limit_hit  = ocnt_reg == OCNT_W'(OUT_LIMIT - 1);
    assign stat.out_ok     = !out_valid_reg || !code_stall;

    assign out_final = (cmd.seg_last && stat.row_done) || stat.limit_hit;

    // Code byte select
    always_comb
    begin
        unique case (cmd.out_sel)
            OSEL_ZERO:  out_byte_next = 8'd0;
            OSEL_COUNT: out_byte_next = 8'(cnt_reg);
            OSEL_VALUE: out_byte_next = first_reg;
            OSEL_DATA:  out_byte_next = rd_data_reg;
        endcase
    end

    // Output register: hold while stalled, drop after transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ocnt_reg      <= '0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
            ocnt_reg      <= out_final ? '0 : ocnt_reg + 1'b1;
        end
        else if (!code_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_byte_reg <= out_byte_next;
            out_end_reg  <= out_final;
            out_len_reg  <= out_final ? LEN_W'(ocnt_reg) + 1'b1 : '0;
        end
    end

    assign code_valid   = out_valid_reg;
    assign code_byte    = out_byte_reg;
    assign code_end     = out_end_reg;
    assign coded_length = out_len_reg;

    // Controller loads the output register only when it can take a byte
    a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_ok)
        else $error("code byte loaded into a full output register");

    // A count byte never goes out as zero or above the cap
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && (cmd.out_sel == OSEL_COUNT)) |->
            ((cnt_reg != '0) && (SUM_W'(cnt_reg) <= SUM_W'(MAX_COUNT))))
        else $error("segment count out of range");

    // Segment start never passes the row length
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= row_len_reg)
        else $error("segment start beyond row length");

    // Length field is nonzero exactly on the last code byte
    a_len_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_end_reg == (out_len_reg != '0)))
        else $error("coded length does not match end mark");

endmodule

// File: design/msp_row_rle_encoder_unit.sv
// ============================================================================
// msp_row_rle_encoder_unit: bitmap row run-length encoder
// Buffers one bitmap row and emits its run-length code at the row's end.
// ============================================================================
// Row bytes transfer one per cycle into a 32-byte row buffer; bytes beyond
// 32 are dropped but the row still closes on row_end. After row_end the
// input stalls while the row is coded from the buffer through its single
// read port: each segment is first scanned, then emitted at one code byte
// per cycle (3 for a repeat, 1 + count for a literal) when the output is
// not stalled. The last code byte carries code_end and the row's coded
// length. The input reopens as soon as the last code byte sits in the
// output register. No clearing pass is needed after reset.
// ============================================================================
module msp_row_rle_encoder_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       row_valid,
    output logic                       row_stall,
    input  logic [7:0]                 row_byte,
    input  logic                       row_end,
    output logic                       code_valid,
    input  logic                       code_stall,
    output logic [7:0]                 code_byte,
    output logic                       code_end,
    output logic [mrre_pkg::LEN_W-1:0] coded_length
);
    import mrre_pkg::*;

    mrre_cmd_t  cmd;
    mrre_stat_t stat;
    logic       row_accept;

    assign row_accept = row_valid && !row_stall;

    // Sequencer
    mrre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_valid (row_valid),
        .row_end   (row_end),
        .row_stall (row_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Row buffer and code datapath
    mrre_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_accept   (row_accept),
        .row_byte     (row_byte),
        .row_end      (row_end),
        .cmd          (cmd),
        .stat         (stat),
        .code_stall   (code_stall),
        .code_valid   (code_valid),
        .code_byte    (code_byte),
        .code_end     (code_end),
        .coded_length (coded_length)
    );

endmodule

// File: test/msp_row_rle_encoder_unit_tb.sv
// ============================================================================
// msp_row_rle_encoder_unit_tb: self-checking bench for the row RLE encoder
// Rows of bytes go in, and each row's code stream is checked byte by byte
// against a behavioral row coder kept in the bench. The bench runs a short
// directed table first, then random rows of several shapes, with random
// gaps and stalls on both sides and one long output hold-off.
// ============================================================================
module msp_row_rle_encoder_unit_tb;

    import mrre_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_ITEMS = 150;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int DIR_N        = 21;

    // One code byte as seen on the output channel
    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [LEN_W-1:0] len;
    } code_item_t;

    // Directed stimulus row; typed_n of zero means the coder predicts it
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [2:0]  typed_n;
        logic [31:0] typed_code;   // first code byte in [31:24]
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [DIR_N] = '{
        // lone zero byte right after reset: literal of one
        '{8'h00, 1'b1, 3'd2, 32'h0100_0000},
        // lone all-ones byte
        '{8'hFF, 1'b1, 3'd2, 32'h01FF_0000},
        // equal pair: repeat of two
        '{8'hA5, 1'b0, 3'd0, 32'h0},
        '{8'hA5, 1'b1, 3'd3, 32'h0002_A500},
        // two different bytes: literal of two
        '{8'h5A, 1'b0, 3'd0, 32'h0},
        '{8'h3C, 1'b1, 3'd3, 32'h025A_3C00},
        // triple then a single byte
        '{8'h11, 1'b0, 3'd0, 32'h0},
        '{8'h11, 1'b0, 3'd0, 32'h0},
        '{8'h11, 1'b0, 3'd0, 32'h0},
        '{8'h22, 1'b1, 3'd0, 32'h0},
        // literal stops where three equal bytes lie ahead
        '{8'h01, 1'b0, 3'd0, 32'h0},
        '{8'h02, 1'b0, 3'd0, 32'h0},
        '{8'h07, 1'b0, 3'd0, 32'h0},
        '{8'h07, 1'b0, 3'd0, 32'h0},
        '{8'h07, 1'b1, 3'd0, 32'h0},
        // alternating bytes: literal of three
        '{8'h80, 1'b0, 3'd0, 32'h0},
        '{8'h7F, 1'b0, 3'd0, 32'h0},
        '{8'h80, 1'b1, 3'd4, 32'h0380_7F80},
        // pair followed by a different byte
        '{8'hC3, 1'b0, 3'd0, 32'h0},
        '{8'hC3, 1'b0, 3'd0, 32'h0},
        '{8'h3C, 1'b1, 3'd0, 32'h0}
    };

    logic             clk;
    logic             rst_n      = 1'b0;
    logic             row_valid  = 1'b0;
    logic             row_stall;
    logic [7:0]       row_byte   = 8'h00;
    logic             row_end    = 1'b0;
    logic             code_valid;
    logic             code_stall = 1'b0;
    logic [7:0]       code_byte;
    logic             code_end;
    logic [LEN_W-1:0] coded_length;

    // Coder state and expected output
    logic [7:0]   row_buf [ROW_BYTES];
    int unsigned  row_fill;
    logic [7:0]   row_code [$];
    code_item_t   pending_code [$];

    int error_count = 0;
    int items_sent  = 0;
    bit hold_done   = 0;
    int idle_cycles = 0;

    msp_row_rle_encoder_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_valid    (row_valid),
        .row_stall    (row_stall),
        .row_byte     (row_byte),
        .row_end      (row_end),
        .code_valid   (code_valid),
        .code_stall   (code_stall),
        .code_byte    (code_byte),
        .code_end     (code_end),
        .coded_length (coded_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Append one byte to the row code, dropping bytes past the output limit
    function automatic void put_code(input int unsigned value);
        if (row_code.size() < OUT_LIMIT)
            row_code.push_back(value[7:0]);
    endfunction

    // Store one row byte; on the row end, code the held row into row_code
    function automatic void predict_row_code(input logic [7:0] data, input logic last);
        int unsigned pos;
        int unsigned run;
        int unsigned lit;
        int unsigned p;
        int unsigned k;
        row_code.delete();
        if (row_fill < ROW_BYTES)
        begin
            row_buf[row_fill] = data;
            row_fill++;
        end
        if (last)
        begin
            pos = 0;
            while (pos < row_fill)
            begin
                run = 1;
                while (pos + run < row_fill && row_buf[pos] == row_buf[pos + run] &&
                       run < MAX_COUNT)
                    run++;
                if (run > 1)
                begin
                    put_code(0);
                    put_code(run);
                    put_code(row_buf[pos]);
                    pos += run;
                end
                else
                begin
                    lit = 0;
                    while (pos + lit < row_fill && lit < MAX_COUNT)
                    begin
                        p = pos + lit;
                        if (p + 2 < row_fill && row_buf[p] == row_buf[p + 1] &&
                            row_buf[p] == row_buf[p + 2])
                            break;
                        lit++;
                    end
                    if (lit == 0)
                        lit = 1;
                    put_code(lit);
                    for (k = 0; k < lit; k++)
                        put_code(row_buf[pos + k]);
                    pos += lit;
                end
            end
            row_fill = 0;
        end
    endfunction

    // Idle length before an item: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    // Offer one row byte, wait for its transfer, then queue its expected code
    task automatic send_item(input logic [7:0] data, input logic last, input int gap,
                             input int typed_n, input logic [31:0] typed_code);
        int k;
        if (gap > 0)
        begin
            row_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        row_valid <= 1'b1;
        row_byte  <= data;
        row_end   <= last;
        do
            @(posedge clk);
        while (row_stall !== 1'b0);
        items_sent++;
        predict_row_code(data, last);
        if (typed_n != 0)
        begin
            row_code.delete();
            for (k = 0; k < typed_n; k++)
                row_code.push_back(typed_code[31 - 8 * k -: 8]);
        end
        for (k = 0; k < row_code.size(); k++)
        begin
            if (k == row_code.size() - 1)
                pending_code.push_back('{row_code[k], 1'b1, LEN_W'(row_code.size())});
            else
                pending_code.push_back('{row_code[k], 1'b0, '0});
        end
    endtask

    // Output stall: quiet, busy and blocked phases, plus one long hold-off
    initial
    begin
        int phase_mode;
        int phase_left;
        phase_mode = 0;
        phase_left = 0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                code_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_mode = $urandom_range(0, 9);
                    phase_left = (phase_mode == 9) ? $urandom_range(10, 40)
                                                   : $urandom_range(8, 40);
                end
                phase_left--;
                if (phase_mode < 3)
                    code_stall <= 1'b0;
                else if (phase_mode < 9)
                    code_stall <= ($urandom_range(0, 2) == 0);
                else
                    code_stall <= 1'b1;
            end
        end
    end

    // Compare each output transfer with the oldest expected code byte
    always @(posedge clk)
    begin
        code_item_t exp_item;
        if (rst_n && code_valid === 1'b1 && code_stall === 1'b0)
        begin
            if (pending_code.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected code byte %02h end %0d length %0d",
                             code_byte, code_end, coded_length);
            end
            else
            begin
                exp_item = pending_code.pop_front();
                if (code_byte !== exp_item.data || code_end !== exp_item.last ||
                    coded_length !== exp_item.len)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("code mismatch: byte %02h/%02h end %0d/%0d length %0d/%0d",
                                 exp_item.data, code_byte, exp_item.last, code_end,
                                 exp_item.len, coded_length);
                end
            end
        end
    end

    // End the run when nothing transfers on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((row_valid && !row_stall) || (code_valid && !code_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout with %0d code bytes outstanding", pending_code.size());
                $display("msp_row_rle_encoder_unit verification failed");
                $finish;
            end
        end
    end

    // Reset, directed table, random rows, drain and verdict
    initial
    begin
        logic [7:0] row_data [40];
        int  row_len;
        int  style;
        int  run_left;
        int  i;
        int  k;
        bit  dense;
        logic [7:0] cur;

        row_fill = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (i = 0; i < DIR_N; i++)
            send_item(DIR_TABLE[i].data, DIR_TABLE[i].last, pick_gap(),
                      DIR_TABLE[i].typed_n, DIR_TABLE[i].typed_code);

        // Random rows of several shapes, some longer than the buffer
        while (items_sent < DIR_N + RANDOM_ITEMS)
        begin
            k = $urandom_range(0, 19);
            if (k == 0)
                row_len = $urandom_range(ROW_BYTES + 1, 40);
            else if (k == 1)
                row_len = ROW_BYTES;
            else if (k == 2)
                row_len = 1;
            else
                row_len = $urandom_range(2, ROW_BYTES);
            style    = $urandom_range(0, 4);
            dense    = ($urandom_range(0, 2) == 0);
            run_left = 0;
            cur      = 8'($urandom);
            for (k = 0; k < row_len; k++)
            begin
                case (style)
                    0: row_data[k] = 8'($urandom);
                    1:
                    begin
                        if (run_left == 0)
                        begin
                            cur      = 8'($urandom);
                            run_left = $urandom_range(1, 6);
                        end
                        run_left--;
                        row_data[k] = cur;
                    end
                    2:
                    begin
                        // equal pairs give the longest code
                        if (k % 2 == 0)
                            cur = 8'($urandom);
                        row_data[k] = cur;
                    end
                    3: row_data[k] = cur;
                    default: row_data[k] = 8'($urandom_range(0, 2)) * 8'h55;
                endcase
            end
            for (k = 0; k < row_len; k++)
                send_item(row_data[k], k == row_len - 1, dense ? 0 : pick_gap(), 0, 32'h0);
        end
        row_valid <= 1'b0;

        // Drain the outstanding code, then allow for stray output
        while (pending_code.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_code.size() == 0)
            $display("msp_row_rle_encoder_unit verification clean");
        else
            $display("msp_row_rle_encoder_unit verification failed");
        $finish;
    end

endmodule
